FILE: hw/rtl/natm_pkg.sv
`default_nettype none

package natm_pkg;

    localparam int unsigned MASK_W      = 60;
    localparam int unsigned HOUR_MASK_W = 24;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned SECS_W      = 17;

    localparam logic [IDX_W-1:0]  HOURS_PER_DAY    = 6'd24;
    localparam logic [IDX_W-1:0]  MINUTES_PER_HOUR = 6'd60;
    localparam logic [IDX_W-1:0]  SECONDS_PER_MIN  = 6'd60;
    localparam logic [SECS_W-1:0] SECONDS_PER_HOUR = 17'd3600;
    localparam logic [SECS_W-1:0] DAY_SECONDS      = 17'd86400;

    // Register indexes on the configuration port (address bits [4:3]).
    localparam logic [1:0] REG_SECOND_MASK = 2'd0;
    localparam logic [1:0] REG_MINUTE_MASK = 2'd1;
    localparam logic [1:0] REG_HOUR_MASK   = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  start;
        logic [IDX_W-1:0]  max;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  idx;
        logic              wrap;
    } scan_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/natm_scan.sv
`default_nettype none

// Circular next-set-bit search, one mask bit per cycle. The request is taken
// on start; done is high in the cycle in which idx points at a set bit.
module natm_scan
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire natm_pkg::scan_req_t req,
    output natm_pkg::scan_rsp_t      rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [natm_pkg::IDX_W-1:0]    idx_reg;
    logic [natm_pkg::IDX_W-1:0]    idx_next;
    logic                          wrap_reg;
    logic                          wrap_next;
    logic [natm_pkg::MASK_W-1:0]   mask_reg;
    logic [natm_pkg::MASK_W-1:0]   mask_next;
    logic [natm_pkg::IDX_W-1:0]    max_reg;
    logic [natm_pkg::IDX_W-1:0]    max_next;
    logic                          hit;

    assign hit = mask_reg[idx_reg];

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        wrap_next = wrap_reg;
        mask_next = mask_reg;
        max_next  = max_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mask_next = req.mask;
            max_next  = req.max;
            // A start at or past the end begins at zero as a wrap.
            if (req.start >= req.max)
            begin
                idx_next  = '0;
                wrap_next = 1'b1;
            end
            else
            begin
                idx_next  = req.start;
                wrap_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                busy_next = 1'b0;
            end
            else if (idx_reg == max_reg - 6'd1)
            begin
                idx_next  = '0;
                wrap_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            wrap_reg <= wrap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        max_reg  <= max_next;
    end

    assign rsp.done = busy_reg & hit;
    assign rsp.idx  = idx_reg;
    assign rsp.wrap = wrap_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/next_alarm_time_matcher_unit.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      now hour, minute, second
// m_axis    out        m_axis_tvalid/tready      match time, seconds until, flags
// apb       in/out     psel/penable/pwrite       second, minute and hour masks
//
// When a mask is empty, an accepted item goes straight to the done state
// with no scan. Otherwise the shared scan unit sets the pace: it is launched
// through a registered start and then tests one mask bit per cycle. It runs
// three to five times per item, the most on the path that carries from the
// second through the minute into the hour. The arithmetic state then forms
// both second counts, and the done state writes the output register once free.
// Reset is asynchronous and active low; all masks reset to one (only hour,
// minute and second zero allowed). s_axis_tready is high only while the
// sequencer is idle. A finished result sits in the output register until taken,
// and the next item may be accepted while it waits.
module next_alarm_time_matcher_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] now_hour, [10:5] now_minute, [16:11] now_second, [23:17] zero
    input  wire logic [23:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] match_hour, [10:5] match_minute, [16:11] match_second,
    // [33:17] seconds_until, [34] fire_now, [35] no_match, [39:36] zero
    output logic [39:0]      m_axis_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOUR_FIRST,
        ST_MIN_ZERO,
        ST_SEC_ZERO,
        ST_MIN_NOW,
        ST_HOUR_NEXT_SEC,
        ST_SEC_NOW,
        ST_MIN_NEXT,
        ST_HOUR_NEXT,
        ST_CALC,
        ST_DONE
    } state_t;

    // Configuration registers.
    logic [natm_pkg::MASK_W-1:0]      sec_mask_reg;
    logic [natm_pkg::MASK_W-1:0]      min_mask_reg;
    logic [natm_pkg::HOUR_MASK_W-1:0] hour_mask_reg;
    logic                             cfg_write;
    logic [natm_pkg::MASK_W-1:0]      hour_mask_ext;

    // Sequencer state and registered outputs.
    state_t                           state_reg;
    state_t                           state_next;
    logic [natm_pkg::HOUR_W-1:0]      now_h_reg;
    logic [natm_pkg::HOUR_W-1:0]      now_h_next;
    logic [natm_pkg::IDX_W-1:0]       now_m_reg;
    logic [natm_pkg::IDX_W-1:0]       now_m_next;
    logic [natm_pkg::IDX_W-1:0]       now_s_reg;
    logic [natm_pkg::IDX_W-1:0]       now_s_next;
    logic [natm_pkg::HOUR_W-1:0]      hit_h_reg;
    logic [natm_pkg::HOUR_W-1:0]      hit_h_next;
    logic [natm_pkg::IDX_W-1:0]       hit_m_reg;
    logic [natm_pkg::IDX_W-1:0]       hit_m_next;
    logic [natm_pkg::IDX_W-1:0]       hit_s_reg;
    logic [natm_pkg::IDX_W-1:0]       hit_s_next;
    logic                             nomatch_reg;
    logic                             nomatch_next;
    logic [natm_pkg::SECS_W-1:0]      now_sec_reg;
    logic [natm_pkg::SECS_W-1:0]      now_sec_next;
    logic [natm_pkg::SECS_W-1:0]      hit_sec_reg;
    logic [natm_pkg::SECS_W-1:0]      hit_sec_next;
    logic                             go_reg;
    logic                             go_next;
    natm_pkg::scan_req_t              req_reg;
    natm_pkg::scan_req_t              req_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [39:0]                      out_data_reg;
    logic [39:0]                      out_data_next;

    natm_pkg::scan_rsp_t              rsp;

    logic                             in_accept;
    logic [natm_pkg::HOUR_W-1:0]      in_h;
    logic [natm_pkg::IDX_W-1:0]       in_m;
    logic [natm_pkg::IDX_W-1:0]       in_s;
    logic [natm_pkg::IDX_W-1:0]       now_h_wide;
    logic [natm_pkg::IDX_W-1:0]       h_plus_one;
    logic [natm_pkg::IDX_W-1:0]       m_plus_one;
    logic [natm_pkg::SECS_W-1:0]      secs_left;
    logic                             out_free;

    function automatic natm_pkg::scan_req_t mk_req(
        input logic [natm_pkg::MASK_W-1:0] mask,
        input logic [natm_pkg::IDX_W-1:0]  start,
        input logic [natm_pkg::IDX_W-1:0]  max
    );
        natm_pkg::scan_req_t r;
        r.mask  = mask;
        r.start = start;
        r.max   = max;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Registers sit at 8-byte strides; the low address
    // bits are not decoded and the fourth slot is unused.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_mask_reg  <= 60'd1;
            min_mask_reg  <= 60'd1;
            hour_mask_reg <= 24'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:3])
                natm_pkg::REG_SECOND_MASK: sec_mask_reg  <= pwdata[59:0];
                natm_pkg::REG_MINUTE_MASK: min_mask_reg  <= pwdata[59:0];
                natm_pkg::REG_HOUR_MASK:   hour_mask_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            natm_pkg::REG_SECOND_MASK: prdata = {4'd0, sec_mask_reg};
            natm_pkg::REG_MINUTE_MASK: prdata = {4'd0, min_mask_reg};
            natm_pkg::REG_HOUR_MASK:   prdata = {40'd0, hour_mask_reg};
            default:                   prdata = '0;
        endcase
    end

    assign hour_mask_ext = {36'd0, hour_mask_reg};

    // ------------------------------------------------------------------
    // Shared scan unit.
    // ------------------------------------------------------------------
    natm_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------
    // Input reduction: hours modulo 24, minutes and seconds modulo 60. One
    // compare and subtract suffices since the raw fields stay below twice
    // the modulus.
    // ------------------------------------------------------------------
    assign in_h = (s_axis_tdata[4:0] >= natm_pkg::HOURS_PER_DAY[4:0]) ?
                  s_axis_tdata[4:0] - natm_pkg::HOURS_PER_DAY[4:0] : s_axis_tdata[4:0];
    assign in_m = (s_axis_tdata[10:5] >= natm_pkg::MINUTES_PER_HOUR) ?
                  s_axis_tdata[10:5] - natm_pkg::MINUTES_PER_HOUR : s_axis_tdata[10:5];
    assign in_s = (s_axis_tdata[16:11] >= natm_pkg::SECONDS_PER_MIN) ?
                  s_axis_tdata[16:11] - natm_pkg::SECONDS_PER_MIN : s_axis_tdata[16:11];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // Hour 23 plus one gives 24 and minute 59 plus one gives 60; the scan unit
    // treats a start at the end as a wrap to zero.
    assign now_h_wide = {1'b0, now_h_reg};
    assign h_plus_one = now_h_wide + 6'd1;
    assign m_plus_one = now_m_reg + 6'd1;

    // Seconds until the match, modulo one day.
    assign secs_left = (hit_sec_reg >= now_sec_reg) ? hit_sec_reg - now_sec_reg :
                       hit_sec_reg + natm_pkg::DAY_SECONDS - now_sec_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer. Each scan state waits for the scan unit and then either
    // launches the next scan or moves on to the arithmetic.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        now_h_next     = now_h_reg;
        now_m_next     = now_m_reg;
        now_s_next     = now_s_reg;
        hit_h_next     = hit_h_reg;
        hit_m_next     = hit_m_reg;
        hit_s_next     = hit_s_reg;
        nomatch_next   = nomatch_reg;
        now_sec_next   = now_sec_reg;
        hit_sec_next   = hit_sec_reg;
        go_next        = 1'b0;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    now_h_next = in_h;
                    now_m_next = in_m;
                    now_s_next = in_s;
                    if (sec_mask_reg == '0 || min_mask_reg == '0 || hour_mask_reg == '0)
                    begin
                        nomatch_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        nomatch_next = 1'b0;
                        go_next      = 1'b1;
                        req_next     = mk_req(hour_mask_ext, {1'b0, in_h},
                                              natm_pkg::HOURS_PER_DAY);
                        state_next   = ST_HOUR_FIRST;
                    end
                end
            end

            ST_HOUR_FIRST:
            begin
                if (rsp.done)
                begin
                    hit_h_next = rsp.idx[4:0];
                    go_next    = 1'b1;
                    if (rsp.idx != now_h_wide)
                    begin
                        // A later hour: earliest minute and second of it.
                        req_next   = mk_req(min_mask_reg, '0, natm_pkg::MINUTES_PER_HOUR);
                        state_next = ST_MIN_ZERO;
                    end
                    else
                    begin
                        req_next   = mk_req(min_mask_reg, now_m_reg,
                                            natm_pkg::MINUTES_PER_HOUR);
                        state_next = ST_MIN_NOW;
                    end
                end
            end

            ST_MIN_ZERO:
            begin
                if (rsp.done)
                begin
                    hit_m_next = rsp.idx;
                    go_next    = 1'b1;
                    req_next   = mk_req(sec_mask_reg, '0, natm_pkg::SECONDS_PER_MIN);
                    state_next = ST_SEC_ZERO;
                end
            end

            ST_SEC_ZERO:
            begin
                if (rsp.done)
                begin
                    hit_s_next = rsp.idx;
                    state_next = ST_CALC;
                end
            end

            ST_MIN_NOW:
            begin
                if (rsp.done)
                begin
                    hit_m_next = rsp.idx;
                    go_next    = 1'b1;
                    if (rsp.wrap)
                    begin
                        // No minute left in this hour: move to a later hour.
                        req_next   = mk_req(hour_mask_ext, h_plus_one,
                                            natm_pkg::HOURS_PER_DAY);
                        state_next = ST_HOUR_NEXT_SEC;
                    end
                    else if (rsp.idx != now_m_reg)
                    begin
                        req_next   = mk_req(sec_mask_reg, '0, natm_pkg::SECONDS_PER_MIN);
                        state_next = ST_SEC_ZERO;
                    end
                    else
                    begin
                        req_next   = mk_req(sec_mask_reg, now_s_reg,
                                            natm_pkg::SECONDS_PER_MIN);
                        state_next = ST_SEC_NOW;
                    end
                end
            end

            ST_HOUR_NEXT_SEC:
            begin
                if (rsp.done)
                begin
                    hit_h_next = rsp.idx[4:0];
                    go_next    = 1'b1;
                    req_next   = mk_req(sec_mask_reg, '0, natm_pkg::SECONDS_PER_MIN);
                    state_next = ST_SEC_ZERO;
                end
            end

            ST_SEC_NOW:
            begin
                if (rsp.done)
                begin
                    hit_s_next = rsp.idx;
                    if (rsp.wrap)
                    begin
                        // Seconds ran out: carry into the minute.
                        go_next    = 1'b1;
                        req_next   = mk_req(min_mask_reg, m_plus_one,
                                            natm_pkg::MINUTES_PER_HOUR);
                        state_next = ST_MIN_NEXT;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end

            ST_MIN_NEXT:
            begin
                if (rsp.done)
                begin
                    hit_m_next = rsp.idx;
                    if (rsp.wrap)
                    begin
                        // Minutes ran out as well: carry into the hour.
                        go_next    = 1'b1;
                        req_next   = mk_req(hour_mask_ext, h_plus_one,
                                            natm_pkg::HOURS_PER_DAY);
                        state_next = ST_HOUR_NEXT;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end

            ST_HOUR_NEXT:
            begin
                if (rsp.done)
                begin
                    hit_h_next = rsp.idx[4:0];
                    state_next = ST_CALC;
                end
            end

            ST_CALC:
            begin
                now_sec_next = 17'(now_h_reg) * natm_pkg::SECONDS_PER_HOUR
                             + 17'(now_m_reg) * 17'(natm_pkg::SECONDS_PER_MIN)
                             + 17'(now_s_reg);
                hit_sec_next = 17'(hit_h_reg) * natm_pkg::SECONDS_PER_HOUR
                             + 17'(hit_m_reg) * 17'(natm_pkg::SECONDS_PER_MIN)
                             + 17'(hit_s_reg);
                state_next   = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (nomatch_reg)
                    begin
                        out_data_next = {4'd0, 1'b1, 1'b0, 17'd0, 6'd0, 6'd0, 5'd0};
                    end
                    else
                    begin
                        out_data_next = {4'd0, 1'b0, (secs_left == '0), secs_left,
                                         hit_s_reg, hit_m_reg, hit_h_reg};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            nomatch_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            nomatch_reg   <= nomatch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_h_reg    <= now_h_next;
        now_m_reg    <= now_m_next;
        now_s_reg    <= now_s_next;
        hit_h_reg    <= hit_h_next;
        hit_m_reg    <= hit_m_next;
        hit_s_reg    <= hit_s_next;
        now_sec_reg  <= now_sec_next;
        hit_sec_reg  <= hit_sec_next;
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
